@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority queue RTL
// Clocked, reset-qualified same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Sizes, codes and shared types of the stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int CAPACITY    = 16;
   localparam int KEY_BITS    = 8;
   localparam int HANDLE_BITS = 16;
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_QUERY = 2'd3
   } spq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NULL  = 2'd3
   } spq_status_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic                   push;
      logic                   pop;
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
   } spq_cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a key and a handle, shifts right on an
// insert ahead of it and left on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic                           clock,
   input  wire spq_pkg::spq_cmd_type           cmd,
   input  wire logic                           occupied,
   input  wire logic                           left_ge,
   input  wire logic [spq_pkg::KEY_BITS-1:0]    left_key,
   input  wire logic [spq_pkg::HANDLE_BITS-1:0] left_handle,
   input  wire logic [spq_pkg::KEY_BITS-1:0]    right_key,
   input  wire logic [spq_pkg::HANDLE_BITS-1:0] right_handle,
   output logic                                ge,
   output logic [spq_pkg::KEY_BITS-1:0]         key,
   output logic [spq_pkg::HANDLE_BITS-1:0]      handle,
   output logic [spq_pkg::HANDLE_BITS-1:0]      handle_next
);

   logic [spq_pkg::KEY_BITS-1:0]    key_ff,    key_in;
   logic [spq_pkg::HANDLE_BITS-1:0] handle_ff, handle_in;

   // Held entry ranks ahead of (or level with) the new key
   assign ge = occupied && (key_ff >= cmd.key);

   // Pick next slot contents: keep, take the new entry, shift in from a neighbour
   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (cmd.push && !ge) begin
         if (left_ge) begin
            key_in    = cmd.key;
            handle_in = cmd.handle;
         end else begin
            key_in    = left_key;
            handle_in = left_handle;
         end
      end else if (cmd.pop) begin
         key_in    = right_key;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign key         = key_ff;
   assign handle      = handle_ff;
   assign handle_next = handle_in;

endmodule

`default_nettype wire

@@ rtl/core/stable_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue, highest key first, equal keys in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode, key, item_data) is taken on a rising edge with start
//   high and busy low. Opcodes: push, pop, clear all, query only.
//   Every request gives exactly one response, shown on the rsp_ ports for
//   one cycle with rsp_valid high, in the cycle after the request is taken.
//   The response is registered; a request may be taken every cycle, since all
//   slots of the sorted row compare with the new key and shift at once.
//   busy is always low: no operation holds off a request.
//   A push with a zero handle is rejected (status null), a push into a full
//   queue is dropped (status full), a pop on an empty queue reports status
//   empty. Responses cannot be held off by the receiver and must be taken
//   in the cycle they appear.
//   Reset empties the queue (entry count zero) and drops any pending
//   response; slot contents are left as they are and never read until
//   written again.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stable_priority_queue_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [spq_pkg::KEY_BITS-1:0]     req_key,
   input  wire logic [spq_pkg::HANDLE_BITS-1:0]  req_item_data,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [spq_pkg::HANDLE_BITS-1:0]       rsp_popped_data,
   output logic [spq_pkg::HANDLE_BITS-1:0]       rsp_head_data,
   output logic                                  rsp_head_valid,
   output logic [spq_pkg::COUNT_BITS-1:0]        rsp_entry_count,
   output logic                                  rsp_is_empty
);

   localparam int N = spq_pkg::CAPACITY;

   logic                             accept;
   spq_pkg::spq_op_type              op;
   spq_pkg::spq_cmd_type             cmd;
   logic                             push_ok, pop_ok;
   logic [1:0]                       status;

   logic [spq_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic                             rsp_valid_ff;
   logic [1:0]                       rsp_status_ff;
   logic [spq_pkg::HANDLE_BITS-1:0]  rsp_popped_ff, rsp_head_ff;
   logic                             rsp_head_valid_ff, rsp_is_empty_ff;
   logic [spq_pkg::COUNT_BITS-1:0]   rsp_count_ff;

   logic [N-1:0]                     occ, ge;
   logic [spq_pkg::KEY_BITS-1:0]     cell_key    [N];
   logic [spq_pkg::HANDLE_BITS-1:0]  cell_handle [N];
   logic [spq_pkg::HANDLE_BITS-1:0]  cell_next   [N];

   // No operation ever holds off a request
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = spq_pkg::spq_op_type'(req_opcode);

   // Decode the request against the fill count
   always_comb begin
      push_ok = 1'b0;
      pop_ok  = 1'b0;
      status  = spq_pkg::ST_OK;
      case (op)
         spq_pkg::OP_PUSH: begin
            if (req_item_data == '0) begin
               status = spq_pkg::ST_NULL;
            end else if (count_ff >= spq_pkg::COUNT_BITS'(N)) begin
               status = spq_pkg::ST_FULL;
            end else begin
               push_ok = accept;
            end
         end
         spq_pkg::OP_POP: begin
            if (count_ff == '0) begin
               status = spq_pkg::ST_EMPTY;
            end else begin
               pop_ok = accept;
            end
         end
         default: status = spq_pkg::ST_OK;
      endcase
   end

   assign cmd.push   = push_ok;
   assign cmd.pop    = pop_ok;
   assign cmd.key    = req_key;
   assign cmd.handle = req_item_data;

   // Update the fill count: push adds one, pop takes one, clear zeroes it
   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end else if (accept && op == spq_pkg::OP_CLEAR) begin
         count_in = '0;
      end
   end

   // Sorted row of cells, front in cell 0
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                             l_ge;
      logic [spq_pkg::KEY_BITS-1:0]     l_key, r_key;
      logic [spq_pkg::HANDLE_BITS-1:0]  l_handle, r_handle;

      assign occ[i] = count_ff > spq_pkg::COUNT_BITS'(i);

      if (i == 0) begin : g_first
         assign l_ge     = 1'b1;
         assign l_key    = req_key;
         assign l_handle = req_item_data;
      end else begin : g_inner
         assign l_ge     = ge[i-1];
         assign l_key    = cell_key[i-1];
         assign l_handle = cell_handle[i-1];
      end

      if (i == N - 1) begin : g_last
         assign r_key    = cell_key[i];
         assign r_handle = cell_handle[i];
      end else begin : g_body
         assign r_key    = cell_key[i+1];
         assign r_handle = cell_handle[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .occupied     (occ[i]),
         .left_ge      (l_ge),
         .left_key     (l_key),
         .left_handle  (l_handle),
         .right_key    (r_key),
         .right_handle (r_handle),
         .ge           (ge[i]),
         .key          (cell_key[i]),
         .handle       (cell_handle[i]),
         .handle_next  (cell_next[i])
      );
   end

   // Hold count and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= accept;
      end
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_popped_ff     <= pop_ok ? cell_handle[0] : '0;
         rsp_head_ff       <= (count_in != '0) ? cell_next[0] : '0;
         rsp_head_valid_ff <= count_in != '0;
         rsp_is_empty_ff   <= count_in == '0;
         rsp_count_ff      <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_popped_data = rsp_popped_ff;
   assign rsp_head_data   = rsp_head_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

   // Checks
   `SPQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= spq_pkg::COUNT_BITS'(N), "fill count beyond capacity")
   `SPQ_ASSERT_NEXT(a_push_grows, clock, reset, push_ok,
      count_ff == $past(count_ff) + 1'b1, "accepted push did not add an entry")
   `SPQ_ASSERT_IMPL(a_rsp_count, clock, reset, rsp_valid_ff,
      rsp_count_ff == count_ff, "reported count differs from held count")
   `SPQ_ASSERT_NEXT(a_empty_pop, clock, reset,
      accept && op == spq_pkg::OP_POP && count_ff == '0,
      rsp_status_ff == spq_pkg::ST_EMPTY && rsp_popped_ff == '0,
      "pop on empty queue not flagged")

endmodule

`default_nettype wire
